/* hdl/dbum_pkg.sv */
// Shared types and constants for the DRAM bank utilization monitor.
// Used by the lane, statistics, top level and checker files.
package dbum_pkg;

    localparam int BANKS = 16;

    // Field widths
    localparam int OP_W     = 2;
    localparam int KIND_W   = 3;
    localparam int BANK_W   = 4;
    localparam int REFC_W   = 10;
    localparam int BURST_W  = 4;
    localparam int TIMING_W = 8;
    localparam int CODE_W   = 4;
    localparam int CNT_W    = 32;
    localparam int MASK_W   = 16;
    localparam int STATES_W = 64;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 224;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Item operations
    localparam logic [OP_W-1:0] OP_CMD      = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_FLAG = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

    // Command kinds
    localparam logic [KIND_W-1:0] CMD_REFRESH   = 3'd0;
    localparam logic [KIND_W-1:0] CMD_READ      = 3'd1;
    localparam logic [KIND_W-1:0] CMD_WRITE     = 3'd2;
    localparam logic [KIND_W-1:0] CMD_ACTIVATE  = 3'd3;
    localparam logic [KIND_W-1:0] CMD_PRECHARGE = 3'd4;

    // Bank state codes
    localparam logic [CODE_W-1:0] ST_NOP    = 4'd0;
    localparam logic [CODE_W-1:0] ST_CLOSED = 4'd1;
    localparam logic [CODE_W-1:0] ST_ACT    = 4'd2;
    localparam logic [CODE_W-1:0] ST_RD     = 4'd3;
    localparam logic [CODE_W-1:0] ST_WR     = 4'd4;
    localparam logic [CODE_W-1:0] ST_PRE    = 4'd5;
    localparam logic [CODE_W-1:0] ST_MISS   = 4'd6;
    localparam logic [CODE_W-1:0] ST_ARB    = 4'd7;
    localparam logic [CODE_W-1:0] ST_REF    = 4'd8;
    localparam logic [CODE_W-1:0] ST_CONF   = 4'd9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REFRESH_CYCLES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BURST       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVATE_CYCLES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRECHARGE_CYCLES = 2'd3;

    // Per-lane control for one transfer
    typedef struct packed {
        logic tick;
        logic ref_active;
        logic ref_flag;
        logic set_rd;
        logic set_wr;
        logic load_act;
        logic load_pre;
        logic queued;
        logic row_open;
        logic read_hit;
        logic write_hit;
        logic any_rd;
        logic any_wr;
    } lane_ctrl_t;

    // Per-lane status back to the merge logic
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              busy;
        logic              rd_mark;
        logic              wr_mark;
    } lane_stat_t;

    // Utilization counter set
    typedef struct packed {
        logic [CNT_W-1:0] busy;
        logic [CNT_W-1:0] refr;
        logic [CNT_W-1:0] rd;
        logic [CNT_W-1:0] wr;
        logic [CNT_W-1:0] ticks;
    } counters_t;

    // Channel-level inputs to the statistics unit
    typedef struct packed {
        logic                accept;
        logic [OP_W-1:0]     op;
        logic [KIND_W-1:0]   cmd_kind;
        logic                in_refresh;
        logic                busy_any;
    } stats_in_t;

endpackage

/* hdl/dbum_lane.sv */
// One bank lane: activate/precharge countdowns, read/write marks, state code.
// Depends on dbum_pkg.
module dbum_lane
    import dbum_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lane_ctrl_t           ctrl,
    input  logic [TIMING_W-1:0]  activate_cycles,
    input  logic [TIMING_W-1:0]  precharge_cycles,
    output lane_stat_t           stat
);

    logic [TIMING_W-1:0] act_reg, act_next;
    logic [TIMING_W-1:0] pre_reg, pre_next;
    logic                rd_reg, rd_next;
    logic                wr_reg, wr_next;
    logic [CODE_W-1:0]   code;
    logic                busy;

    // Classify the bank from its current state
    always_comb begin
        busy = 1'b0;
        priority if (ctrl.ref_active) begin
            code = ST_REF;
        end else if (act_reg != '0) begin
            code = ST_ACT;
            busy = 1'b1;
        end else if (pre_reg != '0) begin
            code = ST_PRE;
            busy = 1'b1;
        end else if (rd_reg) begin
            code = ST_RD;
        end else if (wr_reg) begin
            code = ST_WR;
        end else if (!ctrl.queued) begin
            code = ST_NOP;
        end else begin
            busy = 1'b1;
            priority if (!ctrl.row_open) begin
                code = ST_CLOSED;
            end else if (ctrl.read_hit) begin
                code = ctrl.any_rd ? ST_ARB : ST_CONF;
            end else if (ctrl.write_hit) begin
                code = ctrl.any_wr ? ST_ARB : ST_CONF;
            end else begin
                code = ST_MISS;
            end
        end
    end

    // Advance countdowns on a tick, load them on a command
    always_comb begin
        act_next = act_reg;
        pre_next = pre_reg;
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        if (ctrl.tick) begin
            rd_next = 1'b0;
            wr_next = 1'b0;
            if (ctrl.ref_active) begin
                if (ctrl.ref_flag) begin
                    act_next = '0;
                    pre_next = '0;
                end
            end else if (act_reg != '0) begin
                act_next = act_reg - TIMING_W'(1);
            end else if (pre_reg != '0) begin
                pre_next = pre_reg - TIMING_W'(1);
            end
        end else begin
            if (ctrl.set_rd)   rd_next  = 1'b1;
            if (ctrl.set_wr)   wr_next  = 1'b1;
            if (ctrl.load_act) act_next = activate_cycles;
            if (ctrl.load_pre) pre_next = precharge_cycles;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= '0;
            pre_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            act_reg <= act_next;
            pre_reg <= pre_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    assign stat.code    = code;
    assign stat.busy    = busy & ~ctrl.ref_active;
    assign stat.rd_mark = rd_reg;
    assign stat.wr_mark = wr_reg;

endmodule

/* hdl/dbum_stats.sv */
// Channel-wide state: refresh flag and countdown, data-bus countdowns and
// the wrapping utilization counters. Depends on dbum_pkg.
module dbum_stats
    import dbum_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  stats_in_t           sin,
    input  logic [REFC_W-1:0]   refresh_cycles,
    input  logic [BURST_W-1:0]  half_burst,
    output logic                ref_flag,
    output logic                ref_active,
    output counters_t           cnt_next
);

    logic                ref_flag_reg, ref_flag_next;
    logic [REFC_W-1:0]   ref_left_reg, ref_left_next;
    logic [BURST_W-1:0]  rd_bus_reg, rd_bus_next;
    logic [BURST_W-1:0]  wr_bus_reg, wr_bus_next;
    counters_t           cnt_reg;
    logic                tick;
    logic                cmd;

    assign tick       = sin.accept && (sin.op == OP_TICK);
    assign cmd        = sin.accept && (sin.op == OP_CMD) && !ref_flag_reg;
    assign ref_active = ref_flag_reg || (ref_left_reg != '0);

    always_comb begin
        ref_flag_next = ref_flag_reg;
        ref_left_next = ref_left_reg;
        rd_bus_next   = rd_bus_reg;
        wr_bus_next   = wr_bus_reg;
        cnt_next      = cnt_reg;
        // Load countdowns on a command transfer
        if (cmd) begin
            if (sin.cmd_kind == CMD_REFRESH) ref_left_next = refresh_cycles;
            if (sin.cmd_kind == CMD_READ)    rd_bus_next   = half_burst;
            if (sin.cmd_kind == CMD_WRITE)   wr_bus_next   = half_burst;
        end
        if (sin.accept && (sin.op == OP_SET_FLAG)) begin
            ref_flag_next = sin.in_refresh;
        end
        // Count and advance on a tick
        if (tick) begin
            if (ref_active) begin
                cnt_next.refr = cnt_reg.refr + CNT_W'(1);
                if (!ref_flag_reg) ref_left_next = ref_left_reg - REFC_W'(1);
            end else begin
                if (sin.busy_any && (rd_bus_reg == '0) && (wr_bus_reg == '0)) begin
                    cnt_next.busy = cnt_reg.busy + CNT_W'(1);
                end
                if (rd_bus_reg != '0) begin
                    cnt_next.rd = cnt_reg.rd + CNT_W'(1);
                    rd_bus_next = rd_bus_reg - BURST_W'(1);
                end
                if (wr_bus_reg != '0) begin
                    cnt_next.wr = cnt_reg.wr + CNT_W'(1);
                    wr_bus_next = wr_bus_reg - BURST_W'(1);
                end
            end
            ref_flag_next  = 1'b0;
            cnt_next.ticks = cnt_reg.ticks + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_flag_reg <= 1'b0;
            ref_left_reg <= '0;
            rd_bus_reg   <= '0;
            wr_bus_reg   <= '0;
            cnt_reg      <= '0;
        end else begin
            ref_flag_reg <= ref_flag_next;
            ref_left_reg <= ref_left_next;
            rd_bus_reg   <= rd_bus_next;
            wr_bus_reg   <= wr_bus_next;
            cnt_reg      <= cnt_next;
        end
    end

    assign ref_flag = ref_flag_reg;

endmodule

/* hdl/dram_bank_utilization_monitor_core.sv */
// DRAM bank utilization monitor, top level.
//
// Input stream (s_*): one item per transfer. s_tuser carries the operation
// (issue command, set refresh flag, clock tick); s_tdata carries the command
// kind, bank, refresh flag value and the four per-bank masks used on a tick.
// Output stream (m_*): exactly one result per input item, in order: the
// per-bank state codes (zero unless the item is a tick) and the five
// utilization counters after the item is applied.
// Configuration (cfg_*): register writes, always ready; the user must send
// them so they are taken only while idle, which the block does not enforce.
// Timing: one item per cycle while the output is not stalled; m_tvalid
// rises in the cycle after the input transfer. All banks are classified
// and updated together by sixteen parallel lanes; the OR of the lanes' marks
// and busy flags is merged with the channel counters in the same cycle, and
// the result sits in a single output register.
// Stall: while m_tvalid is high and m_tready low, the result holds and
// s_tready drops; an input is taken in the cycle the result leaves.
// Reset: synchronous, active low; clears all countdowns, marks, counters
// and the output valid flag, and restores the timing registers to defaults.
// Depends on dbum_pkg, dbum_lane and dbum_stats.
module dram_bank_utilization_monitor_core
    import dbum_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [2:0] cmd_kind, [6:3] bank, [7] in_refresh, [23:8] queue_nonempty_mask,
    // [39:24] row_open_mask, [55:40] read_hit_mask, [71:56] write_hit_mask
    input  logic [S_DATA_W-1:0]    s_tdata,
    // [1:0] op
    input  logic [OP_W-1:0]        s_tuser,
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [63:0] bank_states, [95:64] busy_cycles, [127:96] refresh_ticks,
    // [159:128] read_bus_cycles, [191:160] write_bus_cycles,
    // [223:192] tick_count
    output logic [M_DATA_W-1:0]    m_tdata,
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [REFC_W-1:0]    refresh_cycles_reg;
    logic [BURST_W-1:0]   half_burst_reg;
    logic [TIMING_W-1:0]  activate_cycles_reg;
    logic [TIMING_W-1:0]  precharge_cycles_reg;

    logic                 accept;
    logic                 tick;
    logic                 cmd;
    logic [KIND_W-1:0]    cmd_kind;
    logic [BANK_W-1:0]    bank;
    logic [MASK_W-1:0]    q_mask, ro_mask, rh_mask, wh_mask;

    logic                 ref_flag;
    logic                 ref_active;
    logic                 any_rd, any_wr, busy_any;
    logic [BANKS-1:0]     rd_marks, wr_marks, busy_bits;
    lane_ctrl_t           lane_ctrl [BANKS];
    lane_stat_t           lane_stat [BANKS];
    stats_in_t            sin;
    counters_t            cnt_next;
    logic [STATES_W-1:0]  states;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // Unpack the input transfer
    assign cmd_kind = s_tdata[2:0];
    assign bank     = s_tdata[6:3];
    assign q_mask   = s_tdata[23:8];
    assign ro_mask  = s_tdata[39:24];
    assign rh_mask  = s_tdata[55:40];
    assign wh_mask  = s_tdata[71:56];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign tick     = accept && (s_tuser == OP_TICK);
    assign cmd      = accept && (s_tuser == OP_CMD) && !ref_flag;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refresh_cycles_reg   <= REFC_W'(350);
            half_burst_reg       <= BURST_W'(4);
            activate_cycles_reg  <= TIMING_W'(16);
            precharge_cycles_reg <= TIMING_W'(16);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_REFRESH_CYCLES:   refresh_cycles_reg   <= cfg_data;
                REG_HALF_BURST:       half_burst_reg       <= cfg_data[BURST_W-1:0];
                REG_ACTIVATE_CYCLES:  activate_cycles_reg  <= cfg_data[TIMING_W-1:0];
                REG_PRECHARGE_CYCLES: precharge_cycles_reg <= cfg_data[TIMING_W-1:0];
                default: ;
            endcase
        end
    end

    // Bank lanes
    for (genvar i = 0; i < BANKS; i++) begin : g_lane
        always_comb begin
            lane_ctrl[i].tick       = tick;
            lane_ctrl[i].ref_active = ref_active;
            lane_ctrl[i].ref_flag   = ref_flag;
            lane_ctrl[i].set_rd     = cmd && (cmd_kind == CMD_READ)
                                      && (bank == BANK_W'(i));
            lane_ctrl[i].set_wr     = cmd && (cmd_kind == CMD_WRITE)
                                      && (bank == BANK_W'(i));
            lane_ctrl[i].load_act   = cmd && (cmd_kind == CMD_ACTIVATE)
                                      && (bank == BANK_W'(i));
            lane_ctrl[i].load_pre   = cmd && (cmd_kind == CMD_PRECHARGE)
                                      && (bank == BANK_W'(i));
            lane_ctrl[i].queued     = q_mask[i];
            lane_ctrl[i].row_open   = ro_mask[i];
            lane_ctrl[i].read_hit   = rh_mask[i];
            lane_ctrl[i].write_hit  = wh_mask[i];
            lane_ctrl[i].any_rd     = any_rd;
            lane_ctrl[i].any_wr     = any_wr;
        end

        dbum_lane u_lane (
            .aclk             (aclk),
            .aresetn          (aresetn),
            .ctrl             (lane_ctrl[i]),
            .activate_cycles  (activate_cycles_reg),
            .precharge_cycles (precharge_cycles_reg),
            .stat             (lane_stat[i])
        );

        assign rd_marks[i]  = lane_stat[i].rd_mark;
        assign wr_marks[i]  = lane_stat[i].wr_mark;
        assign busy_bits[i] = lane_stat[i].busy;
    end

    // Merge lane results
    assign any_rd   = |rd_marks;
    assign any_wr   = |wr_marks;
    assign busy_any = |busy_bits;

    always_comb begin
        states = '0;
        for (int i = 0; i < BANKS; i++) begin
            states[CODE_W*i +: CODE_W] = tick ? lane_stat[i].code : ST_NOP;
        end
    end

    assign sin.accept     = accept;
    assign sin.op         = s_tuser;
    assign sin.cmd_kind   = cmd_kind;
    assign sin.in_refresh = s_tdata[7];
    assign sin.busy_any   = busy_any;

    dbum_stats u_stats (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sin            (sin),
        .refresh_cycles (refresh_cycles_reg),
        .half_burst     (half_burst_reg),
        .ref_flag       (ref_flag),
        .ref_active     (ref_active),
        .cnt_next       (cnt_next)
    );

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {cnt_next.ticks, cnt_next.wr, cnt_next.rd,
                             cnt_next.refr, cnt_next.busy, states};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* hdl/dbum_checker.sv */
// Port-level checks for the DRAM bank utilization monitor and the bind that
// attaches them to the top level. Depends on dbum_pkg.
module dbum_checker
    import dbum_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [OP_W-1:0]       s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_DATA_W-1:0]   m_tdata
);

    // Reset clears the output valid flag
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Every input transfer yields a result in the next cycle
    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("result missing one cycle after input transfer");

    // Only a tick reports bank states
    a_states_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != OP_TICK) |=> m_tdata[STATES_W-1:0] == '0)
        else $error("bank states nonzero for a non-tick item");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind dram_bank_utilization_monitor_core dbum_checker u_dbum_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/dbum_tb_pkg.sv */
`timescale 1ns / 1ps
// Item and result layouts used by the monitor testbench and its checker.
// Depends on dbum_pkg for field widths and codes.
package dbum_tb_pkg;
    import dbum_pkg::*;

    // Operation with no effect, and the first of the ignored command kinds
    localparam logic [OP_W-1:0]   OP_NONE   = 2'd3;
    localparam logic [KIND_W-1:0] CMD_OTHER = 3'd5;

    // s_tdata layout, lowest field last
    typedef struct packed {
        logic [MASK_W-1:0] wr_hit;
        logic [MASK_W-1:0] rd_hit;
        logic [MASK_W-1:0] row_open;
        logic [MASK_W-1:0] queued;
        logic              in_refresh;
        logic [BANK_W-1:0] bank;
        logic [KIND_W-1:0] kind;
    } item_t;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [CNT_W-1:0]    ticks;
        logic [CNT_W-1:0]    wr;
        logic [CNT_W-1:0]    rd;
        logic [CNT_W-1:0]    refr;
        logic [CNT_W-1:0]    busy;
        logic [STATES_W-1:0] states;
    } util_result_t;

endpackage

/* tb/sv/bank_util_checker.sv */
`timescale 1ns / 1ps
// Checker for the DRAM bank utilization monitor: mirrors bank and counter
// state, predicts each result and compares it field by field.
// Depends on dbum_pkg and dbum_tb_pkg.
module bank_util_checker
    import dbum_pkg::*;
    import dbum_tb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding,
    output int                    compared
);

    // Timing registers
    logic [REFC_W-1:0]   refresh_len;
    logic [BURST_W-1:0]  burst_len;
    logic [TIMING_W-1:0] act_len;
    logic [TIMING_W-1:0] pre_len;

    // Channel and bank state
    logic                ref_flag;
    logic [REFC_W-1:0]   ref_left;
    logic [BANKS-1:0]    rd_mark;
    logic [BANKS-1:0]    wr_mark;
    logic [TIMING_W-1:0] act_left [BANKS];
    logic [TIMING_W-1:0] pre_left [BANKS];
    logic [BURST_W-1:0]  rbus_left;
    logic [BURST_W-1:0]  wbus_left;
    logic [CNT_W-1:0]    n_busy, n_ref, n_rd, n_wr, n_tick;

    util_result_t due_results [$];

    initial begin
        mismatches  = 0;
        compared    = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string field, input logic [STATES_W-1:0] got,
                                   input logic [STATES_W-1:0] want);
        mismatches++;
        // keep the log short when the block is badly broken
        if (mismatches <= 40)
            $display("mismatch %s at result %0d: got %h, want %h", field, compared, got, want);
    endtask

    // Apply one item to the mirrored state and return the result it produces
    function automatic util_result_t advance_monitor(input logic [OP_W-1:0] op,
                                                     input item_t it);
        util_result_t r;
        logic any_rd, any_wr, busy;
        logic [CODE_W-1:0] code;
        r = '0;
        case (op)
            OP_CMD: begin
                // commands are dropped while the refresh flag is up
                if (!ref_flag) begin
                    case (it.kind)
                        CMD_REFRESH: ref_left = refresh_len;
                        CMD_READ: begin
                            rd_mark[it.bank] = 1'b1;
                            rbus_left = burst_len;
                        end
                        CMD_WRITE: begin
                            wr_mark[it.bank] = 1'b1;
                            wbus_left = burst_len;
                        end
                        CMD_ACTIVATE:  act_left[it.bank] = act_len;
                        CMD_PRECHARGE: pre_left[it.bank] = pre_len;
                        default: ;
                    endcase
                end
            end
            OP_SET_FLAG: ref_flag = it.in_refresh;
            OP_TICK: begin
                if (ref_flag || ref_left != '0) begin
                    // whole channel in refresh; the flag also wipes bank timers
                    for (int i = 0; i < BANKS; i++) begin
                        r.states[CODE_W*i +: CODE_W] = ST_REF;
                        if (ref_flag) begin
                            act_left[i] = '0;
                            pre_left[i] = '0;
                        end
                    end
                    if (!ref_flag)
                        ref_left = ref_left - 1'b1;
                    n_ref = n_ref + 1'b1;
                end else begin
                    any_rd = |rd_mark;
                    any_wr = |wr_mark;
                    busy   = 1'b0;
                    for (int i = 0; i < BANKS; i++) begin
                        if (act_left[i] != '0) begin
                            code = ST_ACT;
                            act_left[i] = act_left[i] - 1'b1;
                            busy = 1'b1;
                        end else if (pre_left[i] != '0) begin
                            code = ST_PRE;
                            pre_left[i] = pre_left[i] - 1'b1;
                            busy = 1'b1;
                        end else if (rd_mark[i]) begin
                            code = ST_RD;
                        end else if (wr_mark[i]) begin
                            code = ST_WR;
                        end else if (!it.queued[i]) begin
                            code = ST_NOP;
                        end else begin
                            // queued work waiting on this bank
                            if (!it.row_open[i])
                                code = ST_CLOSED;
                            else if (it.rd_hit[i])
                                code = any_rd ? ST_ARB : ST_CONF;
                            else if (it.wr_hit[i])
                                code = any_wr ? ST_ARB : ST_CONF;
                            else
                                code = ST_MISS;
                            busy = 1'b1;
                        end
                        r.states[CODE_W*i +: CODE_W] = code;
                    end
                    if (busy && rbus_left == '0 && wbus_left == '0)
                        n_busy = n_busy + 1'b1;
                    if (rbus_left != '0) begin
                        n_rd = n_rd + 1'b1;
                        rbus_left = rbus_left - 1'b1;
                    end
                    if (wbus_left != '0) begin
                        n_wr = n_wr + 1'b1;
                        wbus_left = wbus_left - 1'b1;
                    end
                end
                ref_flag = 1'b0;
                rd_mark  = '0;
                wr_mark  = '0;
                n_tick   = n_tick + 1'b1;
            end
            default: ;
        endcase
        r.busy  = n_busy;
        r.refr  = n_ref;
        r.rd    = n_rd;
        r.wr    = n_wr;
        r.ticks = n_tick;
        return r;
    endfunction

    // Track register writes, compare results, then queue new predictions
    always @(posedge aclk) begin : track
        util_result_t got;
        util_result_t want;
        if (!aresetn) begin
            refresh_len = 10'd350;
            burst_len   = 4'd4;
            act_len     = 8'd16;
            pre_len     = 8'd16;
            ref_flag    = 1'b0;
            ref_left    = '0;
            rd_mark     = '0;
            wr_mark     = '0;
            rbus_left   = '0;
            wbus_left   = '0;
            n_busy      = '0;
            n_ref       = '0;
            n_rd        = '0;
            n_wr        = '0;
            n_tick      = '0;
            for (int i = 0; i < BANKS; i++) begin
                act_left[i] = '0;
                pre_left[i] = '0;
            end
            due_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_REFRESH_CYCLES:   refresh_len = cfg_data[REFC_W-1:0];
                    REG_HALF_BURST:       burst_len   = cfg_data[BURST_W-1:0];
                    REG_ACTIVATE_CYCLES:  act_len     = cfg_data[TIMING_W-1:0];
                    REG_PRECHARGE_CYCLES: pre_len     = cfg_data[TIMING_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result, states", got.states, '0);
                end else begin
                    want = due_results.pop_front();
                    if (got.states !== want.states)
                        report_mismatch("bank_states", got.states, want.states);
                    if (got.busy !== want.busy)
                        report_mismatch("busy_cycles", got.busy, want.busy);
                    if (got.refr !== want.refr)
                        report_mismatch("refresh_ticks", got.refr, want.refr);
                    if (got.rd !== want.rd)
                        report_mismatch("read_bus_cycles", got.rd, want.rd);
                    if (got.wr !== want.wr)
                        report_mismatch("write_bus_cycles", got.wr, want.wr);
                    if (got.ticks !== want.ticks)
                        report_mismatch("tick_count", got.ticks, want.ticks);
                    compared++;
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(advance_monitor(s_tuser, s_tdata));
        end
        outstanding <= due_results.size();
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the DRAM bank utilization monitor: drives commands,
// flag writes and ticks under several timing setups, with random stalls.
// Depends on dbum_pkg, dbum_tb_pkg, bank_util_checker and the monitor core.
module tb;
    import dbum_pkg::*;
    import dbum_tb_pkg::*;

    localparam int RESET_CYCLES    = 6;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int SETTLE_CYCLES   = 4;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] = '{
        REG_REFRESH_CYCLES, REG_HALF_BURST, REG_ACTIVATE_CYCLES, REG_PRECHARGE_CYCLES
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int outstanding;
    int compared;
    int items_sent   = 0;
    int setups       = 0;
    int quiet_cycles = 0;
    bit gaps_on      = 1'b1;
    bit hold_off_req = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    dram_bank_utilization_monitor_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bank_util_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    // Abort when no transfer of any kind happens for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random backpressure bursts plus requested long hold-offs
    initial begin : sink
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic item_t tick_of(input logic [MASK_W-1:0] q, ro, rh, wh);
        item_t it;
        it = '0;
        it.queued   = q;
        it.row_open = ro;
        it.rd_hit   = rh;
        it.wr_hit   = wh;
        return it;
    endfunction

    function automatic item_t cmd_of(input logic [KIND_W-1:0] kind,
                                     input logic [BANK_W-1:0] bank);
        item_t it;
        it = '0;
        it.kind = kind;
        it.bank = bank;
        return it;
    endfunction

    function automatic item_t flag_of(input logic value);
        item_t it;
        it = '0;
        it.in_refresh = value;
        return it;
    endfunction

    // Offer one item, with an optional idle burst ahead of it; hold until taken
    task automatic send_item(input logic [OP_W-1:0] op, input item_t it);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= it;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Drop valid and wait until every queued prediction has been matched
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all four timing registers back to back
    task automatic load_timing(input int unsigned refc, burst, act, pre);
        logic [CFG_DATA_W-1:0] vals [4];
        vals[0] = refc[CFG_DATA_W-1:0];
        vals[1] = burst[CFG_DATA_W-1:0];
        vals[2] = act[CFG_DATA_W-1:0];
        vals[3] = pre[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        for (int r = 0; r < 4; r++) begin
            cfg_index <= REG_ORDER[r];
            cfg_data  <= vals[r];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        setups++;
    endtask

    // Mostly ticks and bank commands, some flag writes and dead items
    task automatic send_random(input bit allow_refresh);
        logic [95:0]     raw;
        item_t           it;
        logic [OP_W-1:0] op;
        int unsigned     pick;
        int unsigned     sub;
        raw  = {$urandom, $urandom, $urandom};
        it   = raw[S_DATA_W-1:0];
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        if (pick < 50) begin
            op = OP_TICK;
            // favor open rows with queued work so hits and misses show up
            if (sub < 30) begin
                it.queued   = '1;
                it.row_open = '1;
            end else if (sub < 38) begin
                it.queued = '0;
            end
        end else if (pick < 90) begin
            op = OP_CMD;
            if (sub < 24)
                it.kind = CMD_READ;
            else if (sub < 48)
                it.kind = CMD_WRITE;
            else if (sub < 70)
                it.kind = CMD_ACTIVATE;
            else if (sub < 92)
                it.kind = CMD_PRECHARGE;
            else if (sub < 97 || !allow_refresh)
                it.kind = CMD_OTHER + 3'($urandom_range(0, 2));
            else
                it.kind = CMD_REFRESH;
        end else if (pick < 97) begin
            op = OP_SET_FLAG;
        end else begin
            op = OP_NONE;
        end
        send_item(op, it);
    endtask

    task automatic random_run(input int count, input bit allow_refresh);
        repeat (count) send_random(allow_refresh);
    endtask

    initial begin : stimulus
        item_t mix;
        mix = tick_of('1, '1, 16'hAAAA, 16'h5555);
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: classification with reset timing
        send_item(OP_TICK, tick_of('0, '0, '0, '0));
        send_item(OP_TICK, tick_of('1, '0, '0, '0));
        send_item(OP_TICK, tick_of('1, '1, '0, '0));
        send_item(OP_CMD, cmd_of(CMD_READ, 4'd0));
        send_item(OP_CMD, cmd_of(CMD_WRITE, 4'd15));
        send_item(OP_TICK, mix);
        send_item(OP_TICK, mix);
        send_item(OP_CMD, cmd_of(CMD_ACTIVATE, 4'd3));
        send_item(OP_CMD, cmd_of(CMD_PRECHARGE, 4'd7));
        send_item(OP_CMD, cmd_of(CMD_OTHER, 4'd1));
        send_item(OP_CMD, cmd_of(3'd7, 4'd2));
        send_item(OP_NONE, '1);
        send_item(OP_TICK, tick_of('1, '1, '1, '1));
        // commands under the refresh flag are dropped; the flagged tick
        // clears bank timers
        send_item(OP_SET_FLAG, flag_of(1'b1));
        send_item(OP_CMD, cmd_of(CMD_READ, 4'd4));
        send_item(OP_CMD, cmd_of(CMD_ACTIVATE, 4'd5));
        send_item(OP_TICK, mix);
        send_item(OP_TICK, mix);
        send_item(OP_SET_FLAG, flag_of(1'b1));
        send_item(OP_SET_FLAG, flag_of(1'b0));
        send_item(OP_TICK, tick_of('1, '1, '1, '0));

        // Directed: short refresh countdown
        wait_drained();
        load_timing(2, 4, 16, 16);
        send_item(OP_CMD, cmd_of(CMD_REFRESH, 4'd9));
        repeat (3) send_item(OP_TICK, mix);

        // Random: reset timing, then all-zero timing
        wait_drained();
        load_timing(350, 4, 16, 16);
        random_run(80, 1'b0);
        wait_drained();
        load_timing(0, 0, 0, 0);
        random_run(80, 1'b1);

        // Random at maximum timing, then one long refresh run to its end
        wait_drained();
        load_timing(1023, 15, 255, 255);
        random_run(80, 1'b0);
        wait_drained();
        load_timing(300, 15, 255, 255);
        send_item(OP_SET_FLAG, flag_of(1'b0));
        send_item(OP_CMD, cmd_of(CMD_REFRESH, 4'd0));
        repeat (302) send_item(OP_TICK, mix);

        // Small timing with a long receiver hold-off to back up the input
        wait_drained();
        load_timing(5, 2, 3, 4);
        hold_off_req = 1'b1;
        random_run(120, 1'b1);

        // Random timing; the tail runs without idle cycles
        wait_drained();
        load_timing($urandom_range(0, 12), $urandom_range(0, 15),
                    $urandom_range(0, 40), $urandom_range(0, 40));
        hold_off_req = 1'b1;
        random_run(60, 1'b1);
        gaps_on = 1'b0;
        random_run(60, 1'b1);
        wait_drained();

        $display("summary: %0d items over %0d timing setups, %0d results compared",
                 items_sent, setups, compared);
        $display("summary: %0d mismatching fields", mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
